### sv/iiee_pkg.sv
// Shared types and constants for the infix integer expression evaluator.
// Used by iiee_mdu and infix_integer_expression_evaluator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package iiee_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int RESULT_WIDTH       = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MULOP_NONE = 2'd0,
      MULOP_MUL  = 2'd1,
      MULOP_DIV  = 2'd2
   } mulop_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_MUL,
      CLS_DIV,
      CLS_ADD,
      CLS_SUB,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUM,
      ST_WAIT,
      ST_TERM,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_RUN,
      MDU_FIX
   } mdu_state_type;

   typedef struct packed {
      logic      start;
      mulop_type op;
   } mdu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_sts_type;

endpackage

`default_nettype wire

### sv/iiee_mdu.sv
// Bit-serial multiply / signed divide unit, one bit per cycle.
// Depends on iiee_pkg for the operation code and control/status structs.
`timescale 1ns / 1ps
`default_nettype none

module iiee_mdu #(
   parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  iiee_pkg::mdu_ctl_type       ctl,
   input  wire [DATA_WIDTH-1:0]        opa,
   input  wire [DATA_WIDTH-1:0]        opb,
   output iiee_pkg::mdu_sts_type       sts,
   output logic [DATA_WIDTH-1:0]       result
);

   localparam int CW = $clog2(DATA_WIDTH);

   iiee_pkg::mdu_state_type state_ff, state_in;
   iiee_pkg::mulop_type     op_ff, op_in;
   logic [DATA_WIDTH-1:0]   acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]   sh_ff, sh_in;
   logic [DATA_WIDTH-1:0]   opb_ff, opb_in;
   logic                    neg_ff, neg_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]   result_ff, result_in;
   logic                    done_ff, done_in;

   logic [DATA_WIDTH:0]     rem_shift;
   logic [DATA_WIDTH:0]     diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iiee_pkg::MDU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      opb_ff    <= opb_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      sh_in     = sh_ff;
      opb_in    = opb_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      rem_shift = {acc_ff, sh_ff[DATA_WIDTH-1]};
      diff      = rem_shift - {1'b0, opb_ff};

      unique case (state_ff)
         iiee_pkg::MDU_IDLE: begin
            if (ctl.start) begin
               op_in  = ctl.op;
               cnt_in = '0;
               acc_in = '0;
               if (ctl.op == iiee_pkg::MULOP_MUL) begin
                  sh_in  = opb;
                  opb_in = opa;
                  neg_in = 1'b0;
               end else begin
                  // divide on magnitudes, fix the sign at the end
                  sh_in  = opa[DATA_WIDTH-1] ? -opa : opa;
                  opb_in = opb[DATA_WIDTH-1] ? -opb : opb;
                  neg_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
               end
               state_in = iiee_pkg::MDU_RUN;
            end
         end
         iiee_pkg::MDU_RUN: begin
            if (op_ff == iiee_pkg::MULOP_MUL) begin
               if (sh_ff[0]) acc_in = acc_ff + opb_ff;
               opb_in = opb_ff << 1;
               sh_in  = sh_ff >> 1;
            end else begin
               if (!diff[DATA_WIDTH]) begin
                  acc_in = diff[DATA_WIDTH-1:0];
                  sh_in  = {sh_ff[DATA_WIDTH-2:0], 1'b1};
               end else begin
                  acc_in = rem_shift[DATA_WIDTH-1:0];
                  sh_in  = {sh_ff[DATA_WIDTH-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DATA_WIDTH - 1)) state_in = iiee_pkg::MDU_FIX;
         end
         iiee_pkg::MDU_FIX: begin
            if (op_ff == iiee_pkg::MULOP_MUL) result_in = acc_ff;
            else result_in = neg_ff ? -sh_ff : sh_ff;
            done_in  = 1'b1;
            state_in = iiee_pkg::MDU_IDLE;
         end
         default: state_in = iiee_pkg::MDU_IDLE;
      endcase
   end

   assign sts.busy = (state_ff != iiee_pkg::MDU_IDLE);
   assign sts.done = done_ff;
   assign result   = result_ff;

endmodule

`default_nettype wire

### sv/infix_integer_expression_evaluator.sv
// Top level of the infix integer expression evaluator: character decode,
// accumulators, control sequencer and result register. Depends on iiee_pkg, iiee_mdu.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-------------------------------------
//   req     | in        | req_valid/stall  | req_char_code[7:0], req_end_of_expr
//   rsp     | out       | rsp_valid/stall  | rsp_result_value[31:0], rsp_div_by_zero
//
// A digit or ignored character is taken while idle; an operator passes through the
// number close, and + or - also through the term update. A closing multiply or divide
// runs in the serial unit. The end mark adds one more close and an emit step.
// Reset is synchronous and clears the sequencer and all accumulators.
// A stalled response holds in its output register; new beats are taken
// meanwhile and the sequencer only waits when a second result is ready.
`timescale 1ns / 1ps
`default_nettype none

module infix_integer_expression_evaluator #(
   parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_char_code,
   input  wire                 req_end_of_expr,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_div_by_zero
);

   localparam int RW = iiee_pkg::RESULT_WIDTH;

   // sequencer
   iiee_pkg::ctrl_state_type state_ff, state_in;
   iiee_pkg::char_class_type class_ff, class_in;
   logic                     last_ff, last_in;    // beat carried the end mark
   logic                     final_ff, final_in;  // doing the closing pass

   // expression state
   logic [DATA_WIDTH-1:0]    number_ff, number_in;
   logic [DATA_WIDTH-1:0]    term_ff, term_in;
   logic [DATA_WIDTH-1:0]    sum_ff, sum_in;
   iiee_pkg::mulop_type      mulop_ff, mulop_in;
   logic                     sign_ff, sign_in;
   logic                     zdiv_ff, zdiv_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [RW-1:0]     rsp_value_ff, rsp_value_in;
   logic                     rsp_dbz_ff, rsp_dbz_in;

   iiee_pkg::mdu_ctl_type    mdu_ctl;
   iiee_pkg::mdu_sts_type    mdu_sts;
   logic [DATA_WIDTH-1:0]    mdu_result;

   iiee_pkg::char_class_type req_class;
   logic [3:0]               digit_val;
   logic                     req_fire;
   logic                     emit_fire;
   logic                     num_closed;

   iiee_mdu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mdu_ctl),
      .opa    (term_ff),
      .opb    (number_ff),
      .sts    (mdu_sts),
      .result (mdu_result)
   );

   // classify the incoming character
   always_comb begin
      unique case (req_char_code) inside
         [iiee_pkg::CHAR_ZERO:iiee_pkg::CHAR_NINE]: req_class = iiee_pkg::CLS_DIGIT;
         iiee_pkg::CHAR_STAR:  req_class = iiee_pkg::CLS_MUL;
         iiee_pkg::CHAR_SLASH: req_class = iiee_pkg::CLS_DIV;
         iiee_pkg::CHAR_PLUS:  req_class = iiee_pkg::CLS_ADD;
         iiee_pkg::CHAR_MINUS: req_class = iiee_pkg::CLS_SUB;
         iiee_pkg::CHAR_SPACE, iiee_pkg::CHAR_EQUAL: req_class = iiee_pkg::CLS_OTHER;
         default: req_class = iiee_pkg::CLS_OTHER;
      endcase
   end

   assign digit_val = 4'(req_char_code - iiee_pkg::CHAR_ZERO);
   assign req_stall = (state_ff != iiee_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == iiee_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // launch the serial unit when a real multiply or a nonzero divide closes
   assign mdu_ctl.start = (state_ff == iiee_pkg::ST_NUM) &&
                          ((mulop_ff == iiee_pkg::MULOP_MUL) ||
                           ((mulop_ff == iiee_pkg::MULOP_DIV) && (number_ff != '0)));
   assign mdu_ctl.op    = mulop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iiee_pkg::ST_IDLE;
         final_ff     <= 1'b0;
         number_ff    <= '0;
         term_ff      <= '0;
         sum_ff       <= '0;
         mulop_ff     <= iiee_pkg::MULOP_NONE;
         sign_ff      <= 1'b0;
         zdiv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         final_ff     <= final_in;
         number_ff    <= number_in;
         term_ff      <= term_in;
         sum_ff       <= sum_in;
         mulop_ff     <= mulop_in;
         sign_ff      <= sign_in;
         zdiv_ff      <= zdiv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      class_ff     <= class_in;
      last_ff      <= last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dbz_ff   <= rsp_dbz_in;
   end

   always_comb begin
      state_in     = state_ff;
      class_in     = class_ff;
      last_in      = last_ff;
      final_in     = final_ff;
      number_in    = number_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      mulop_in     = mulop_ff;
      sign_in      = sign_ff;
      zdiv_in      = zdiv_ff;
      rsp_value_in = rsp_value_ff;
      rsp_dbz_in   = rsp_dbz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      num_closed   = 1'b0;

      unique case (state_ff)
         iiee_pkg::ST_IDLE: begin
            if (req_fire) begin
               class_in = req_class;
               last_in  = req_end_of_expr;
               if (req_class == iiee_pkg::CLS_DIGIT) begin
                  // n * 10 + d, wrapping at the data width
                  number_in = (number_ff << 3) + (number_ff << 1) +
                              DATA_WIDTH'(digit_val);
               end
               if (req_class != iiee_pkg::CLS_DIGIT && req_class != iiee_pkg::CLS_OTHER) begin
                  state_in = iiee_pkg::ST_NUM;
               end else if (req_end_of_expr) begin
                  final_in = 1'b1;
                  state_in = iiee_pkg::ST_NUM;
               end
            end
         end
         iiee_pkg::ST_NUM: begin
            if (mdu_ctl.start) begin
               state_in = iiee_pkg::ST_WAIT;
            end else begin
               // plain operand, or divide by zero: quotient zero, flag it
               if (mulop_ff == iiee_pkg::MULOP_NONE) term_in = number_ff;
               else term_in = '0;
               if (mulop_ff == iiee_pkg::MULOP_DIV) zdiv_in = 1'b1;
               num_closed = 1'b1;
            end
         end
         iiee_pkg::ST_WAIT: begin
            if (mdu_sts.done) begin
               term_in    = mdu_result;
               num_closed = 1'b1;
            end
         end
         iiee_pkg::ST_TERM: begin
            sum_in   = sign_ff ? (sum_ff - term_ff) : (sum_ff + term_ff);
            term_in  = '0;
            mulop_in = iiee_pkg::MULOP_NONE;
            if (final_ff) begin
               state_in = iiee_pkg::ST_EMIT;
            end else begin
               sign_in = (class_ff == iiee_pkg::CLS_SUB);
               if (last_ff) begin
                  final_in = 1'b1;
                  state_in = iiee_pkg::ST_NUM;
               end else begin
                  state_in = iiee_pkg::ST_IDLE;
               end
            end
         end
         iiee_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = RW'($signed(sum_ff));
               rsp_dbz_in   = zdiv_ff;
               // drop the whole expression state
               number_in    = '0;
               term_in      = '0;
               sum_in       = '0;
               mulop_in     = iiee_pkg::MULOP_NONE;
               sign_in      = 1'b0;
               zdiv_in      = 1'b0;
               final_in     = 1'b0;
               state_in     = iiee_pkg::ST_IDLE;
            end
         end
         default: state_in = iiee_pkg::ST_IDLE;
      endcase

      // after the number joins the term, advance by what the beat asked for
      if (num_closed) begin
         number_in = '0;
         if (final_ff || class_ff == iiee_pkg::CLS_ADD || class_ff == iiee_pkg::CLS_SUB) begin
            state_in = iiee_pkg::ST_TERM;
         end else begin
            mulop_in = (class_ff == iiee_pkg::CLS_MUL) ? iiee_pkg::MULOP_MUL
                                                       : iiee_pkg::MULOP_DIV;
            if (last_ff) begin
               final_in = 1'b1;
               state_in = iiee_pkg::ST_NUM;
            end else begin
               state_in = iiee_pkg::ST_IDLE;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_div_by_zero  = rsp_dbz_ff;

`ifndef SYNTHESIS
   // a divide is never launched with a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (mdu_ctl.start && mdu_ctl.op == iiee_pkg::MULOP_DIV) |-> (number_ff != '0))
      else $error("divide launched with zero divisor");

   // the serial unit is idle whenever it is launched
   assert property (@(posedge clock) disable iff (reset)
      mdu_ctl.start |-> !mdu_sts.busy)
      else $error("serial unit launched while busy");

   // a finished product or quotient only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mdu_sts.done |-> (state_ff == iiee_pkg::ST_WAIT))
      else $error("serial result arrived outside wait state");

   // emitting a result clears the expression state
   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (sum_ff == '0 && term_ff == '0 && !zdiv_ff && rsp_valid_ff &&
                     state_ff == iiee_pkg::ST_IDLE))
      else $error("state not cleared after emit");
`endif

endmodule

`default_nettype wire
